// File: rtl/sawsat_pkg.sv
// shared types and constants for the stop-and-wait sender with adaptive timeout
// no dependencies
package sawsat_pkg;

  localparam int FRAG_W     = 16;
  localparam int OUT_TIME_W = 24;
  localparam int CFG_W      = 24;
  localparam int CFG_ADDR_W = 1;
  localparam int KIND_W     = 2;

  // input word kinds (code 3 has no meaning and is ignored)
  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REPLY = 2'd2;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_TOTAL_FRAGMENTS = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_INITIAL_TIMEOUT = 1'd1;

  localparam logic [FRAG_W-1:0] TOTAL_FRAGMENTS_RST = 16'd1;
  localparam logic [CFG_W-1:0]  INITIAL_TIMEOUT_RST = 24'd99999;

  typedef enum logic [1:0] {
    ACT_NONE       = 2'd0,
    ACT_SEND_NEW   = 2'd1,
    ACT_RETRANSMIT = 2'd2,
    ACT_COMPLETE   = 2'd3
  } action_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              reply_is_ack;
  } step_t;

  typedef struct packed {
    action_t               action;
    logic [FRAG_W-1:0]     fragment_number;
    logic [OUT_TIME_W-1:0] current_timeout;
    logic [OUT_TIME_W-1:0] rtt_sample;
  } result_t;

endpackage

// File: rtl/sawsat_rtt_est.sv
// rtt estimator update: estimate by 1/8, deviation by 1/4, timeout = est + 4*dev
// no dependencies; pure combinational logic
module sawsat_rtt_est #(
  parameter int TIME_BITS = 24
) (
  input  logic [TIME_BITS-1:0] est,
  input  logic [TIME_BITS-1:0] dev,
  input  logic [TIME_BITS-1:0] sample,
  output logic [TIME_BITS-1:0] est_nxt,
  output logic [TIME_BITS-1:0] dev_nxt,
  output logic [TIME_BITS-1:0] timeout_nxt
);

  localparam logic [TIME_BITS+2:0] TMAX_EXT = (TIME_BITS+3)'({TIME_BITS{1'b1}});

  logic signed [TIME_BITS:0] est_diff;
  logic signed [TIME_BITS:0] est_step;
  logic signed [TIME_BITS:0] err;
  logic [TIME_BITS-1:0]      err_abs;
  logic signed [TIME_BITS:0] dev_diff;
  logic signed [TIME_BITS:0] dev_step;
  logic [TIME_BITS+2:0]      to_sum;

  // arithmetic shifts floor toward minus infinity
  assign est_diff = $signed({1'b0, sample}) - $signed({1'b0, est});
  assign est_step = est_diff >>> 3;
  assign est_nxt  = est + est_step[TIME_BITS-1:0];

  assign err      = $signed({1'b0, sample}) - $signed({1'b0, est_nxt});
  assign err_abs  = err[TIME_BITS] ? TIME_BITS'(-err) : err[TIME_BITS-1:0];
  assign dev_diff = $signed({1'b0, err_abs}) - $signed({1'b0, dev});
  assign dev_step = dev_diff >>> 2;
  assign dev_nxt  = dev + dev_step[TIME_BITS-1:0];

  assign to_sum = {3'b000, est_nxt} + {1'b0, dev_nxt, 2'b00};

  always_comb begin
    if (to_sum > TMAX_EXT) begin
      timeout_nxt = {TIME_BITS{1'b1}};
    end else if (to_sum == '0) begin
      timeout_nxt = TIME_BITS'(1);
    end else begin
      timeout_nxt = to_sum[TIME_BITS-1:0];
    end
  end

endmodule

// File: rtl/sawsat_core.sv
// sender state, configuration registers and per-word step logic
// depends on sawsat_pkg and sawsat_rtt_est
module sawsat_core #(
  parameter int TIME_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [sawsat_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [sawsat_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                                  step_en,
  input  sawsat_pkg::step_t                     step,
  output sawsat_pkg::result_t                   step_res
);
  import sawsat_pkg::*;

  localparam int CW = (TIME_BITS > OUT_TIME_W) ? TIME_BITS : OUT_TIME_W;
  localparam logic [CW-1:0]        TMAX_C  = CW'({TIME_BITS{1'b1}});
  localparam logic [CW-1:0]        INIT_C  = CW'(INITIAL_TIMEOUT_RST);
  localparam logic [TIME_BITS-1:0] TO_RST  =
    (INIT_C > TMAX_C) ? {TIME_BITS{1'b1}} : INIT_C[TIME_BITS-1:0];

  logic [FRAG_W-1:0]    total_r;
  logic [CFG_W-1:0]     init_to_r;
  logic                 busy_r, busy_nxt;
  logic [FRAG_W-1:0]    frag_r, frag_nxt;
  logic [TIME_BITS-1:0] elapsed_r, elapsed_nxt;
  logic [TIME_BITS-1:0] est_r, est_nxt;
  logic [TIME_BITS-1:0] dev_r, dev_nxt;
  logic [TIME_BITS-1:0] timeout_r, timeout_nxt;
  logic [TIME_BITS-1:0] sample_r, sample_nxt;

  logic [FRAG_W-1:0]    total_eff;
  logic [CW-1:0]        init_ext;
  logic [TIME_BITS-1:0] init_to_clamped;
  logic [TIME_BITS-1:0] elapsed_inc;
  logic [TIME_BITS-1:0] upd_est, upd_dev, upd_timeout;
  action_t              action;
  logic [CW-1:0]        timeout_ext, sample_ext;

  sawsat_rtt_est #(.TIME_BITS(TIME_BITS)) u_est (
    .est         (est_r),
    .dev         (dev_r),
    .sample      (elapsed_r),
    .est_nxt     (upd_est),
    .dev_nxt     (upd_dev),
    .timeout_nxt (upd_timeout)
  );

  // zero fragment count means one fragment
  assign total_eff = (total_r == '0) ? FRAG_W'(1) : total_r;

  assign init_ext = CW'(init_to_r);
  always_comb begin
    if (init_ext > TMAX_C) begin
      init_to_clamped = {TIME_BITS{1'b1}};
    end else if (init_ext == '0) begin
      init_to_clamped = TIME_BITS'(1);
    end else begin
      init_to_clamped = init_ext[TIME_BITS-1:0];
    end
  end

  // elapsed count saturates
  assign elapsed_inc = (elapsed_r == {TIME_BITS{1'b1}}) ? elapsed_r : elapsed_r + 1'b1;

  always_comb begin
    busy_nxt    = busy_r;
    frag_nxt    = frag_r;
    elapsed_nxt = elapsed_r;
    est_nxt     = est_r;
    dev_nxt     = dev_r;
    timeout_nxt = timeout_r;
    sample_nxt  = sample_r;
    action      = ACT_NONE;
    unique case (step.kind)
      KIND_START: begin
        if (!busy_r) begin
          busy_nxt    = 1'b1;
          frag_nxt    = FRAG_W'(1);
          elapsed_nxt = '0;
          est_nxt     = '0;
          dev_nxt     = '0;
          sample_nxt  = '0;
          timeout_nxt = init_to_clamped;
          action      = ACT_SEND_NEW;
        end
      end
      KIND_TICK: begin
        if (busy_r) begin
          if (elapsed_inc >= timeout_r) begin
            elapsed_nxt = '0;
            action      = ACT_RETRANSMIT;
          end else begin
            elapsed_nxt = elapsed_inc;
          end
        end
      end
      KIND_REPLY: begin
        if (busy_r) begin
          sample_nxt  = elapsed_r;
          est_nxt     = upd_est;
          dev_nxt     = upd_dev;
          timeout_nxt = upd_timeout;
          elapsed_nxt = '0;
          if (step.reply_is_ack) begin
            if (frag_r >= total_eff) begin
              busy_nxt = 1'b0;
              action   = ACT_COMPLETE;
            end else begin
              frag_nxt = frag_r + 1'b1;
              action   = ACT_SEND_NEW;
            end
          end else begin
            action = ACT_RETRANSMIT;
          end
        end
      end
      default: begin
        action = ACT_NONE;
      end
    endcase
  end

  assign timeout_ext = CW'(timeout_nxt);
  assign sample_ext  = CW'(sample_nxt);

  always_comb begin
    step_res.action          = action;
    step_res.fragment_number = frag_nxt;
    step_res.current_timeout = timeout_ext[OUT_TIME_W-1:0];
    step_res.rtt_sample      = sample_ext[OUT_TIME_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r   <= TOTAL_FRAGMENTS_RST;
      init_to_r <= INITIAL_TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_TOTAL_FRAGMENTS: total_r   <= cfg_wdata[FRAG_W-1:0];
        REG_INITIAL_TIMEOUT: init_to_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      frag_r    <= '0;
      elapsed_r <= '0;
      est_r     <= '0;
      dev_r     <= '0;
      timeout_r <= TO_RST;
      sample_r  <= '0;
    end else if (step_en) begin
      busy_r    <= busy_nxt;
      frag_r    <= frag_nxt;
      elapsed_r <= elapsed_nxt;
      est_r     <= est_nxt;
      dev_r     <= dev_nxt;
      timeout_r <= timeout_nxt;
      sample_r  <= sample_nxt;
    end
  end

endmodule

// File: rtl/stop_and_wait_sender_adaptive_timeout.sv
// stop-and-wait sender: each accepted word is staged in the input register, then its result is registered
// throughput one word per cycle unless out_tready stalls; input register, one step of logic, result register
// the step logic is one pass: saturating count compare, or the rtt estimator chain
// reset (rst_n low, synchronous): idle, fragment 0, estimator cleared,
// timeout from the default initial timeout, both channels empty
// depends on sawsat_pkg and sawsat_core
module stop_and_wait_sender_adaptive_timeout #(
  parameter int TIME_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [sawsat_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [sawsat_pkg::CFG_W-1:0]      cfg_wdata,
  // input words
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,  // [0] reply_is_ack, [7:1] zero
  input  logic [1:0]                        in_tuser,  // [1:0] kind
  // result words
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [63:0]                       out_tdata, // [15:0] fragment_number,
                                                       // [39:16] current_timeout,
                                                       // [63:40] rtt_sample
  output logic [1:0]                        out_tuser  // [1:0] action
);
  import sawsat_pkg::*;

  // input stage register
  logic    in_valid_r, in_valid_nxt;
  step_t   in_step_r;
  // result register
  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r;

  logic    in_acc;
  logic    advance;   // result register can take a new word this cycle
  logic    step_en;   // the staged word is processed this cycle
  result_t step_res;

  assign advance   = !out_valid_r || out_tready;
  assign step_en   = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;
  assign in_acc    = in_tvalid && in_tready;

  // the state update and the result capture happen on the same edge,
  // so the next staged word always sees the updated state
  sawsat_core #(.TIME_BITS(TIME_BITS)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .step_en   (step_en),
    .step      (in_step_r),
    .step_res  (step_res)
  );

  always_comb begin
    if (in_acc) begin
      in_valid_nxt = 1'b1;
    end else if (step_en) begin
      in_valid_nxt = 1'b0;
    end else begin
      in_valid_nxt = in_valid_r;
    end
  end

  always_comb begin
    if (step_en) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_step_r.kind         <= in_tuser;
      in_step_r.reply_is_ack <= in_tdata[0];
    end
    if (step_en) begin
      out_res_r <= step_res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.action;
  assign out_tdata  = {out_res_r.rtt_sample, out_res_r.current_timeout,
                       out_res_r.fragment_number};

  // a new fragment is never numbered zero
  a_send_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.action == ACT_SEND_NEW |-> out_res_r.fragment_number != '0)
    else $error("send of fragment zero");

  // a retransmit only happens during a transfer, so a fragment is current
  a_retx_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.action == ACT_RETRANSMIT |-> out_res_r.fragment_number != '0)
    else $error("retransmit with no current fragment");

  // a staged word moves into an empty result register on the next edge
  a_stage_drains: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !out_valid_r |=> out_valid_r)
    else $error("staged word not moved to result register");

  // result register only fills when a staged word was there
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r && !in_valid_r |=> !out_valid_r)
    else $error("result appeared without an input word");

endmodule
